// ===== design/rpd_pkg.sv =====
// Shared types and constants for the block-adaptive Rice pixel decoder.
package rpd_pkg;

    localparam int MAX_BLOCK_SIZE_DEF = 16;
    localparam int CODE_W             = 3;
    localparam int SPLIT_MAX          = 5;
    localparam int RAW_W              = 8;

    localparam logic [15:0] PIXEL_COUNT_RST = 16'd4096;
    localparam logic [4:0]  BLOCK_SIZE_RST  = 5'd16;

    localparam logic [7:0] CFG_PIXEL_COUNT = 8'd0;
    localparam logic [7:0] CFG_BLOCK_SIZE  = 8'd1;

    localparam logic [2:0] CODE_REPEAT = 3'd0;
    localparam logic [2:0] CODE_RAW    = 3'd7;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_TRAIL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_CODE  = 3'd1,
        PH_RUN   = 3'd2,
        PH_LOW   = 3'd3,
        PH_RAW   = 3'd4,
        PH_DONE  = 3'd5,
        PH_FILL  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        SEQ_IDLE   = 2'd0,
        SEQ_RUN    = 2'd1,
        SEQ_STATUS = 2'd2,
        SEQ_FLUSH  = 2'd3
    } seq_t;

    typedef struct packed {
        logic [15:0] bits;
        logic [3:0]  pend;
        logic [3:0]  width;
    } take_req_t;

    typedef struct packed {
        logic [7:0]  val;
        logic [15:0] bits;
        logic [3:0]  pend;
    } take_rsp_t;

endpackage

// ===== design/rpd_bitunit.sv =====
// Shared bit extractor: pulls the top bits of the pending stream window.
module rpd_bitunit
    import rpd_pkg::*;
(
    input  take_req_t req,
    output take_rsp_t rsp
);

    logic [3:0]  width_eff;
    logic [3:0]  remain;
    logic [15:0] shifted;
    logic [15:0] val_mask;
    logic [15:0] keep_mask;

    always_comb begin
        width_eff = (req.width > req.pend) ? req.pend : req.width;
        remain    = req.pend - width_eff;
        shifted   = req.bits >> remain;
        val_mask  = (16'd1 << width_eff) - 16'd1;
        keep_mask = (16'd1 << remain) - 16'd1;
        rsp.val   = 8'(shifted & val_mask);
        rsp.bits  = req.bits & keep_mask;
        rsp.pend  = remain;
    end

endmodule

// ===== design/rice_pixel_decoder_8bit.sv =====
// Top level of the block-adaptive Rice pixel decoder, one stream byte per item.
//
//  channel | direction | handshake                 | payload
//  s_      | in        | s_tvalid / s_tready       | tdata code_byte, tlast last_byte
//  m_      | out       | m_tvalid / m_tready       | tdata pixel, status; tuser; tlast
//  cfg_    | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  A coded byte is decoded in steps: each code field, each unary run bit including the
//  stop bit, each low or raw field and each pixel of a repeat block; a first byte or a
//  byte after the final pixel skips to status. All work runs through one bit extractor.
//  A result waits in a hold register until the next one shows whether it is last.
//  The sequencer stalls on a new result while hold and output register are full and m_tready is low.
//  aresetn is synchronous; it restores the register defaults and the decoder.
module rice_pixel_decoder_8bit
    import rpd_pkg::*;
#(
    parameter int MAX_BLOCK_SIZE = MAX_BLOCK_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] code_byte
    input  logic        s_tlast,    // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] pixel, [9:8] status, [15:10] zero
    output logic        m_tuser,    // pixel_valid
    output logic        m_tlast,    // last_result

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int POS_W = $clog2(MAX_BLOCK_SIZE + 1);

    logic [15:0] pixel_count_reg;
    logic [4:0]  block_size_reg;

    seq_t        seq_reg, seq_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] bits_reg, bits_next;
    logic [3:0]  pend_reg, pend_next;
    logic [7:0]  run_reg, run_next;
    logic [7:0]  prev_reg, prev_next;
    logic [15:0] count_reg, count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]  split_reg, split_next;
    logic        is_last_reg, is_last_next;
    logic        done_before_reg, done_before_next;

    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_pixel_reg, hold_pixel_next;
    logic        hold_pv_reg, hold_pv_next;
    status_t     hold_st_reg, hold_st_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_pixel_reg, m_pixel_next;
    logic        m_pv_reg, m_pv_next;
    status_t     m_st_reg, m_st_next;
    logic        m_last_reg, m_last_next;

    take_req_t   take_req;
    take_rsp_t   take_rsp;

    logic        s_accept;
    logic        out_free;
    logic        stop;
    logic        take_go;
    logic        emit;
    logic [7:0]  emit_val;
    logic [2:0]  low_split;
    logic [7:0]  delta;
    logic [15:0] count_limit;
    logic [4:0]  block_limit;
    logic [15:0] count_inc;
    logic [4:0]  pos_inc;
    logic        prod;
    logic [7:0]  prod_pixel;
    logic        prod_pv;
    status_t     prod_st;
    logic        stall;

    rpd_bitunit u_bitunit (
        .req (take_req),
        .rsp (take_rsp)
    );

    assign s_tready  = (seq_reg == SEQ_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_st_reg, m_pixel_reg};
    assign m_tuser  = m_pv_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        count_limit = (pixel_count_reg == 16'd0) ? 16'd1 : pixel_count_reg;
        if (block_size_reg == 5'd0) begin
            block_limit = 5'd1;
        end else if (block_size_reg > 5'(MAX_BLOCK_SIZE)) begin
            block_limit = 5'(MAX_BLOCK_SIZE);
        end else begin
            block_limit = block_size_reg;
        end
        count_inc = count_reg + 16'd1;
        pos_inc   = 5'(pos_reg) + 5'd1;
        low_split = (split_reg == CODE_REPEAT || split_reg == CODE_RAW)
                    ? 3'(SPLIT_MAX) : split_reg - 3'd1;
    end

    // decode step: pick the field width for the bit extractor
    always_comb begin
        stop     = 1'b0;
        take_go  = 1'b0;
        emit     = 1'b0;
        emit_val = 8'd0;
        take_req.bits  = bits_reg;
        take_req.pend  = pend_reg;
        take_req.width = 4'd0;
        unique case (phase_reg)
            PH_CODE: begin
                if (pend_reg < 4'(CODE_W)) begin
                    stop = 1'b1;
                end else begin
                    take_req.width = 4'(CODE_W);
                    take_go        = 1'b1;
                end
            end
            PH_FILL: begin
                emit = 1'b1;
            end
            PH_RUN: begin
                if (pend_reg == 4'd0) begin
                    stop = 1'b1;
                end else begin
                    take_req.width = 4'd1;
                    take_go        = 1'b1;
                end
            end
            PH_LOW: begin
                if (pend_reg < 4'(low_split)) begin
                    stop = 1'b1;
                end else begin
                    take_req.width = 4'(low_split);
                    take_go        = 1'b1;
                    emit           = 1'b1;
                    emit_val       = (run_reg << low_split) + take_rsp.val;
                end
            end
            PH_RAW: begin
                if (pend_reg < 4'(RAW_W)) begin
                    stop = 1'b1;
                end else begin
                    take_req.width = 4'(RAW_W);
                    take_go        = 1'b1;
                    emit           = 1'b1;
                    emit_val       = take_rsp.val;
                end
            end
            default: begin
                stop = 1'b1;
            end
        endcase
        delta = emit_val[0] ? {1'b1, ~emit_val[7:1]} : {1'b0, emit_val[7:1]};
    end

    always_comb begin
        prod       = 1'b0;
        prod_pixel = 8'd0;
        prod_pv    = 1'b0;
        prod_st    = ST_OK;
        if (seq_reg == SEQ_RUN && emit) begin
            prod       = 1'b1;
            prod_pixel = prev_reg + delta;
            prod_pv    = 1'b1;
        end else if (seq_reg == SEQ_STATUS && is_last_reg) begin
            prod = 1'b1;
            if (done_before_reg) begin
                prod_st = ST_TRAIL;
            end else if (phase_reg == PH_DONE) begin
                prod_st = ST_OK;
            end else begin
                prod_st = ST_TRUNC;
            end
        end
        stall = prod && hold_valid_reg && !out_free;
    end

    // sequencer next state
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_accept) begin
                    seq_next = (phase_reg == PH_FIRST || phase_reg == PH_DONE)
                               ? SEQ_STATUS : SEQ_RUN;
                end
            end
            SEQ_RUN: begin
                if (!stall && stop) begin
                    seq_next = SEQ_STATUS;
                end
            end
            SEQ_STATUS: begin
                if (!stall) begin
                    seq_next = SEQ_FLUSH;
                end
            end
            SEQ_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    seq_next = SEQ_IDLE;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // decoder state and result path
    always_comb begin
        phase_next       = phase_reg;
        bits_next        = bits_reg;
        pend_next        = pend_reg;
        run_next         = run_reg;
        prev_next        = prev_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        split_next       = split_reg;
        is_last_next     = is_last_reg;
        done_before_next = done_before_reg;
        hold_valid_next  = hold_valid_reg;
        hold_pixel_next  = hold_pixel_reg;
        hold_pv_next     = hold_pv_reg;
        hold_st_next     = hold_st_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_pixel_next     = m_pixel_reg;
        m_pv_next        = m_pv_reg;
        m_st_next        = m_st_reg;
        m_last_next      = m_last_reg;

        if (s_accept) begin
            is_last_next     = s_tlast;
            done_before_next = (phase_reg == PH_DONE);
            if (phase_reg == PH_FIRST) begin
                prev_next  = s_tdata;
                count_next = 16'd0;
                pos_next   = '0;
                bits_next  = 16'd0;
                pend_next  = 4'd0;
                phase_next = PH_CODE;
            end else if (phase_reg != PH_DONE) begin
                pend_next = {1'b1, pend_reg[2:0]};
                bits_next = {bits_reg[7:0], s_tdata};
            end
        end

        if (seq_reg == SEQ_RUN && !stall && !stop) begin
            if (take_go) begin
                bits_next = take_rsp.bits;
                pend_next = take_rsp.pend;
            end
            unique case (phase_reg)
                PH_CODE: begin
                    split_next = take_rsp.val[2:0];
                    if (take_rsp.val[2:0] == CODE_REPEAT) begin
                        phase_next = PH_FILL;
                    end else if (take_rsp.val[2:0] == CODE_RAW) begin
                        phase_next = PH_RAW;
                    end else begin
                        run_next   = 8'd0;
                        phase_next = PH_RUN;
                    end
                end
                PH_RUN: begin
                    if (take_rsp.val[0]) begin
                        phase_next = PH_LOW;
                    end else begin
                        run_next = run_reg + 8'd1;
                    end
                end
                PH_LOW: begin
                    run_next   = 8'd0;
                    phase_next = PH_RUN;
                end
                default: begin
                end
            endcase
            if (emit) begin
                prev_next  = prod_pixel;
                count_next = count_inc;
                pos_next   = POS_W'(pos_inc);
                if (count_inc >= count_limit) begin
                    phase_next = PH_DONE;
                end else if (pos_inc >= block_limit) begin
                    pos_next   = '0;
                    phase_next = PH_CODE;
                end
            end
        end

        if (seq_reg == SEQ_STATUS && is_last_reg && !stall) begin
            phase_next = PH_FIRST;
            bits_next  = 16'd0;
            pend_next  = 4'd0;
            run_next   = 8'd0;
            prev_next  = 8'd0;
            count_next = 16'd0;
            pos_next   = '0;
            split_next = 3'd0;
        end

        if (prod && !stall) begin
            if (hold_valid_reg) begin
                m_valid_next = 1'b1;
                m_pixel_next = hold_pixel_reg;
                m_pv_next    = hold_pv_reg;
                m_st_next    = hold_st_reg;
                m_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_pixel_next = prod_pixel;
            hold_pv_next    = prod_pv;
            hold_st_next    = prod_st;
        end

        if (seq_reg == SEQ_FLUSH && hold_valid_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_pixel_next    = hold_pixel_reg;
            m_pv_next       = hold_pv_reg;
            m_st_next       = hold_st_reg;
            m_last_next     = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_count_reg <= PIXEL_COUNT_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_PIXEL_COUNT) begin
                pixel_count_reg <= cfg_data;
            end else if (cfg_index == CFG_BLOCK_SIZE) begin
                block_size_reg <= cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg         <= SEQ_IDLE;
            phase_reg       <= PH_FIRST;
            bits_reg        <= 16'd0;
            pend_reg        <= 4'd0;
            run_reg         <= 8'd0;
            prev_reg        <= 8'd0;
            count_reg       <= 16'd0;
            pos_reg         <= '0;
            split_reg       <= 3'd0;
            is_last_reg     <= 1'b0;
            done_before_reg <= 1'b0;
            hold_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            seq_reg         <= seq_next;
            phase_reg       <= phase_next;
            bits_reg        <= bits_next;
            pend_reg        <= pend_next;
            run_reg         <= run_next;
            prev_reg        <= prev_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            split_reg       <= split_next;
            is_last_reg     <= is_last_next;
            done_before_reg <= done_before_next;
            hold_valid_reg  <= hold_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_pixel_reg <= hold_pixel_next;
        hold_pv_reg    <= hold_pv_next;
        hold_st_reg    <= hold_st_next;
        m_pixel_reg    <= m_pixel_next;
        m_pv_reg       <= m_pv_next;
        m_st_reg       <= m_st_next;
        m_last_reg     <= m_last_next;
    end

    a_ready_hold_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !hold_valid_reg)
        else $error("input ready with a result still held");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> seq_reg != SEQ_IDLE)
        else $error("sequencer idle after accepting an item");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_pv_reg) |-> m_last_reg)
        else $error("status result not marked last");

    a_fill_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FILL) |-> (seq_reg == SEQ_RUN))
        else $error("repeat block pending outside decode run");

endmodule

// ===== tb/rice_pixel_decoder_8bit_test.sv =====
`timescale 1ns / 100ps
// Testbench for the Rice pixel decoder: encoded streams in, predicted pixels and status checked.
module rice_pixel_decoder_8bit_test;
    import rpd_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESULT_CAP     = 49;
    localparam int SETTLE         = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 80;
    localparam int SMALL_COUNT    = 24;
    localparam logic [7:0] CFG_UNUSED = 8'hA5;

    typedef struct {
        logic [7:0] pixel;
        logic       valid;
        logic       last;
        status_t    status;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data = 16'd0;

    // decoder copy
    logic [15:0] cfg_count;
    logic [4:0]  cfg_block;
    logic [15:0] bit_acc;
    logic [3:0]  bit_fill;
    logic [7:0]  run_len;
    logic [7:0]  prev_pixel;
    logic [15:0] pixels_out;
    logic [4:0]  block_pos;
    logic [2:0]  block_code;
    phase_t      phase;

    pixel_result_t step_q[$];
    pixel_result_t pixel_q[$];
    bit            stream_bits[$];

    int errors = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit steady = 1'b0;

    rice_pixel_decoder_8bit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    function automatic void reset_decoder();
        bit_acc = 16'd0;
        bit_fill = 4'd0;
        run_len = 8'd0;
        prev_pixel = 8'd0;
        pixels_out = 16'd0;
        block_pos = 5'd0;
        block_code = 3'd0;
        phase = PH_FIRST;
    endfunction

    function automatic int count_limit();
        return (cfg_count == 16'd0) ? 1 : int'(cfg_count);
    endfunction

    function automatic int block_limit();
        if (cfg_block == 5'd0) return 1;
        if (cfg_block > MAX_BLOCK_SIZE_DEF) return MAX_BLOCK_SIZE_DEF;
        return int'(cfg_block);
    endfunction

    function automatic int take_bits(int width);
        int have;
        int val;
        have = bit_fill;
        if (width > have) width = have;
        val = (int'(bit_acc) >> (have - width)) & ((1 << width) - 1);
        have -= width;
        bit_fill = 4'(have);
        bit_acc = 16'(int'(bit_acc) & ((1 << have) - 1));
        return val;
    endfunction

    function automatic void add_result(logic [7:0] pixel, logic valid, status_t status);
        pixel_result_t r;
        r.pixel = pixel;
        r.valid = valid;
        r.last = 1'b0;
        r.status = status;
        if (step_q.size() < RESULT_CAP) step_q.push_back(r);
    endfunction

    function automatic void emit_pixel(int code_val);
        logic [7:0] v;
        logic [7:0] delta;
        v = code_val[7:0];
        delta = v[0] ? ~(v >> 1) : (v >> 1);
        prev_pixel = prev_pixel + delta;
        add_result(prev_pixel, 1'b1, ST_OK);
        pixels_out = pixels_out + 16'd1;
        block_pos = block_pos + 5'd1;
        if (pixels_out >= count_limit()) begin
            phase = PH_DONE;
        end else if (block_pos >= block_limit()) begin
            block_pos = 5'd0;
            phase = PH_CODE;
        end
    endfunction

    function automatic void run_decoder();
        int code;
        int split;
        int low;
        while (1'b1) begin
            case (phase)
                PH_CODE: begin
                    if (bit_fill < CODE_W) return;
                    code = take_bits(CODE_W);
                    block_code = code[2:0];
                    if (code == CODE_REPEAT) begin
                        do
                            emit_pixel(0);
                        while (phase == PH_CODE && block_pos != 5'd0);
                    end else if (code <= SPLIT_MAX + 1) begin
                        run_len = 8'd0;
                        phase = PH_RUN;
                    end else begin
                        phase = PH_RAW;
                    end
                end
                PH_RUN: begin
                    if (bit_fill == 4'd0) return;
                    if (take_bits(1) == 0) run_len = run_len + 8'd1;
                    else phase = PH_LOW;
                end
                PH_LOW: begin
                    split = int'(block_code) - 1;
                    if (split < 0 || split > SPLIT_MAX) split = SPLIT_MAX;
                    if (bit_fill < split) return;
                    low = take_bits(split);
                    code = (int'(run_len) << split) + low;
                    run_len = 8'd0;
                    phase = PH_RUN;
                    emit_pixel(code);
                end
                PH_RAW: begin
                    if (bit_fill < RAW_W) return;
                    emit_pixel(take_bits(RAW_W));
                end
                default: return;
            endcase
        end
    endfunction

    function automatic void decode_byte(logic [7:0] code_byte, logic last_byte);
        logic    done_before;
        status_t st;
        done_before = (phase == PH_DONE);
        step_q.delete();
        if (phase == PH_FIRST) begin
            prev_pixel = code_byte;
            pixels_out = 16'd0;
            block_pos = 5'd0;
            bit_acc = 16'd0;
            bit_fill = 4'd0;
            phase = PH_CODE;
        end else if (phase != PH_DONE) begin
            bit_fill = bit_fill & 4'd7;
            bit_acc = {bit_acc[7:0], code_byte};
            bit_fill = bit_fill + 4'd8;
            run_decoder();
        end
        if (last_byte) begin
            if (done_before) st = ST_TRAIL;
            else if (phase == PH_DONE) st = ST_OK;
            else st = ST_TRUNC;
            add_result(8'd0, 1'b0, st);
            reset_decoder();
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) pixel_q.push_back(step_q[i]);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        pixel_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: result expected none actual pixel %0h flag %b last %b status %0d",
                         $time, m_tdata[7:0], m_tuser, m_tlast, m_tdata[9:8]);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                check_field("pixel", int'(want.pixel), int'(m_tdata[7:0]));
                check_field("pixel_valid", int'(want.valid), int'(m_tuser));
                check_field("last_result", int'(want.last), int'(m_tlast));
                check_field("status", int'(want.status), int'(m_tdata[9:8]));
                check_field("padding", 0, int'(m_tdata[15:10]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_sink
        int gap;
        forever begin
            gap = steady ? 0 : $urandom_range(0, 15);
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    task automatic send_byte(input logic [7:0] code_byte, input logic last_byte);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code_byte;
        s_tlast <= last_byte;
        do @(posedge aclk); while (s_tready !== 1'b1);
        decode_byte(code_byte, last_byte);
        items_sent++;
    endtask

    task automatic park_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        if (index == CFG_PIXEL_COUNT) cfg_count = value;
        else if (index == CFG_BLOCK_SIZE) cfg_block = value[4:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void put_bits(int value, int width);
        for (int i = width - 1; i >= 0; i--) stream_bits.push_back(value[i]);
    endfunction

    function automatic void put_pixel(int code, int run, int low);
        if (code == CODE_RAW) begin
            put_bits(low, RAW_W);
        end else begin
            repeat (run) stream_bits.push_back(1'b0);
            stream_bits.push_back(1'b1);
            put_bits(low, code - 1);
        end
    endfunction

    task automatic send_stream(input logic [7:0] first_pixel, input int drop_bytes,
                               input int extra_bytes);
        logic [7:0] stream_bytes[$];
        logic [7:0] b;
        while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
        for (int i = 0; i < stream_bits.size(); i += 8) begin
            for (int j = 0; j < 8; j++) b[7 - j] = stream_bits[i + j];
            stream_bytes.push_back(b);
        end
        stream_bits.delete();
        repeat (drop_bytes) if (stream_bytes.size() > 0) void'(stream_bytes.pop_back());
        repeat (extra_bytes) stream_bytes.push_back(8'($urandom_range(0, 255)));
        if (stream_bytes.size() == 0) begin
            send_byte(first_pixel, 1'b1);
        end else begin
            send_byte(first_pixel, 1'b0);
            foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        end
        park_input();
    endtask

    task automatic test_result_cap();
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        park_input();
    endtask

    task automatic test_split_modes();
        write_reg(CFG_PIXEL_COUNT, 16'd10);
        write_reg(CFG_BLOCK_SIZE, 16'd1);
        put_bits(CODE_REPEAT, CODE_W);
        put_bits(1, CODE_W); put_pixel(1, 0, 0);
        put_bits(1, CODE_W); put_pixel(1, 5, 0);
        put_bits(2, CODE_W); put_pixel(2, 3, 1);
        put_bits(3, CODE_W); put_pixel(3, 0, 3);
        put_bits(4, CODE_W); put_pixel(4, 2, 0);
        put_bits(5, CODE_W); put_pixel(5, 1, 15);
        put_bits(6, CODE_W); put_pixel(6, 4, 31);
        put_bits(CODE_RAW, CODE_W); put_pixel(CODE_RAW, 0, 255);
        put_bits(CODE_RAW, CODE_W); put_pixel(CODE_RAW, 0, 0);
        send_stream(8'h00, 0, 0);
    endtask

    task automatic test_status_cases();
        write_reg(CFG_PIXEL_COUNT, 16'd2);
        write_reg(CFG_BLOCK_SIZE, 16'd16);
        put_bits(CODE_RAW, CODE_W);
        put_pixel(CODE_RAW, 0, 1);
        put_pixel(CODE_RAW, 0, 128);
        send_stream(8'hFF, 0, 2);
        put_bits(6, CODE_W);
        put_pixel(6, 1, 31);
        put_pixel(6, 0, 0);
        send_stream(8'h80, 1, 0);
        send_byte(8'h33, 1'b1);
        park_input();
        write_reg(CFG_PIXEL_COUNT, 16'd0);
        put_bits(3, CODE_W);
        put_pixel(3, 1, 2);
        send_stream(8'h7E, 0, 0);
        write_reg(CFG_PIXEL_COUNT, 16'd3);
        write_reg(CFG_BLOCK_SIZE, 16'd0);
        for (int i = 0; i < 3; i++) begin
            put_bits(2, CODE_W);
            put_pixel(2, i, i);
        end
        send_stream(8'h10, 0, 0);
        write_reg(CFG_PIXEL_COUNT, 16'd20);
        write_reg(CFG_BLOCK_SIZE, 16'hFFFF);
        put_bits(CODE_REPEAT, CODE_W);
        put_bits(1, CODE_W);
        repeat (4) put_pixel(1, 0, 0);
        send_stream(8'hC3, 0, 0);
        write_reg(CFG_UNUSED, 16'h1234);
        write_reg(CFG_PIXEL_COUNT, 16'hFFFF);
        put_bits(CODE_RAW, CODE_W);
        put_pixel(CODE_RAW, 0, 170);
        put_pixel(CODE_RAW, 0, 85);
        send_stream(8'h01, 0, 0);
    endtask

    task automatic test_run_wrap();
        write_reg(CFG_PIXEL_COUNT, 16'd1);
        write_reg(CFG_BLOCK_SIZE, 16'd1);
        put_bits(1, CODE_W);
        put_pixel(1, 260, 0);
        send_stream(8'h40, 0, 0);
    endtask

    task automatic test_random_streams();
        int start;
        int form;
        int target;
        int made;
        int code;
        int n;
        logic [15:0] value;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                value = 16'($urandom_range(1, SMALL_COUNT));
                if ($urandom_range(0, 7) == 0) value = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                write_reg(CFG_PIXEL_COUNT, value);
            end
            if ($urandom_range(0, 2) == 0) begin
                value = 16'($urandom_range(0, 65535));
                case ($urandom_range(0, 9))
                    0: value[4:0] = 5'd0;
                    1: value[4:0] = 5'($urandom_range(17, 31));
                    default: value[4:0] = 5'($urandom_range(1, 16));
                endcase
                write_reg(CFG_BLOCK_SIZE, value);
            end
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), i == n - 1);
                park_input();
            end else begin
                target = count_limit();
                if (target > SMALL_COUNT) target = $urandom_range(1, SMALL_COUNT);
                made = 0;
                while (made < target) begin
                    code = $urandom_range(0, 7);
                    put_bits(code, CODE_W);
                    if (code == CODE_REPEAT) begin
                        made += block_limit();
                    end else begin
                        for (int p = 0; p < block_limit() && made < target; p++) begin
                            put_pixel(code,
                                      ($urandom_range(0, 15) == 0) ? $urandom_range(6, 20)
                                                                   : $urandom_range(0, 3),
                                      $urandom_range(0, 255));
                            made++;
                        end
                    end
                end
                form = $urandom_range(0, 9);
                if (form < 7) begin
                    send_stream(8'($urandom_range(0, 255)), 0, 0);
                end else if (form < 9) begin
                    send_stream(8'($urandom_range(0, 255)), $urandom_range(1, 2), 0);
                end else begin
                    send_stream(8'($urandom_range(0, 255)), 0, $urandom_range(1, 3));
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin : main
        cfg_count = PIXEL_COUNT_RST;
        cfg_block = BLOCK_SIZE_RST;
        reset_decoder();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_result_cap();
        test_split_modes();
        test_status_cases();
        test_run_wrap();
        test_random_streams();
        wait_idle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
